>>> hw/rtl/zvd_pkg.sv
// Shared types and constants for the zero-velocity detector.
// No dependencies; zvd_norm, zero_velocity_detector and zvd_checker use this package.
`timescale 1ns / 1ps
`default_nettype none
package zvd_pkg;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic               window_end;
  } in_item_t;

  typedef struct packed {
    logic       stationary;
    logic [1:0] test_status;
    logic [7:0] still_count;
  } out_item_t;

  localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [1:0] REG_REF_MEAN    = 2'd1;
  localparam logic [1:0] REG_REF_STD     = 2'd2;

  localparam logic [1:0] ST_TESTED   = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_TOO_FEW  = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  localparam logic [7:0] STILL_LIMIT = 8'd5;
  localparam logic [7:0] COUNT_MAX   = 8'd255;
  localparam logic [31:0] F_FACTOR   = 32'd20;

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_EVAL, S_DIV, S_VAR, S_MUL, S_CMP, S_EMIT
  } main_state_t;

  typedef enum logic [1:0] {
    NS_IDLE, NS_SQ, NS_ROOT
  } norm_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/zvd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module zvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/zvd_norm.sv
// Vector norm unit: squares three components on one multiplier, then takes
// the integer square root one result bit per cycle. Depends on zvd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module zvd_norm (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] vx,
  input  wire logic signed [31:0] vy,
  input  wire logic signed [31:0] vz,
  output logic                    done,
  output logic             [31:0] norm
);

  zvd_pkg::norm_state_t state_r, state_nxt;

  logic [31:0] mag_r [3];
  logic [1:0]  idx_r;
  logic [63:0] prod_r;
  logic        prodv_r;
  logic [63:0] acc_r;
  logic [63:0] rem_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic        done_r;
  logic [31:0] norm_r;

  logic [31:0] mag_sel;
  logic [63:0] trial;
  logic        take;
  logic [63:0] res_new;

  function automatic logic [31:0] magnitude(input logic signed [31:0] v);
    magnitude = v[31] ? (~v + 32'd1) : v;
  endfunction

  always_comb begin
    case (idx_r)
      2'd0:    mag_sel = mag_r[0];
      2'd1:    mag_sel = mag_r[1];
      2'd2:    mag_sel = mag_r[2];
      default: mag_sel = '0;
    endcase
  end

  assign trial   = res_r + bit_r;
  assign take    = rem_r >= trial;
  assign res_new = take ? ((res_r >> 1) + bit_r) : (res_r >> 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zvd_pkg::NS_IDLE: if (start) state_nxt = zvd_pkg::NS_SQ;
      zvd_pkg::NS_SQ:   if (idx_r == 2'd3) state_nxt = zvd_pkg::NS_ROOT;
      zvd_pkg::NS_ROOT: if (bit_r == 64'd1) state_nxt = zvd_pkg::NS_IDLE;
      default:          state_nxt = zvd_pkg::NS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zvd_pkg::NS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == zvd_pkg::NS_ROOT) && (bit_r == 64'd1);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      zvd_pkg::NS_IDLE: begin
        mag_r[0] <= magnitude(vx);
        mag_r[1] <= magnitude(vy);
        mag_r[2] <= magnitude(vz);
        idx_r    <= 2'd0;
        acc_r    <= '0;
        prodv_r  <= 1'b0;
      end
      zvd_pkg::NS_SQ: begin
        // product of the previous cycle lands in the accumulator
        prod_r  <= mag_sel * mag_sel;
        prodv_r <= idx_r != 2'd3;
        idx_r   <= idx_r + 2'd1;
        if (prodv_r) acc_r <= acc_r + prod_r;
        if (idx_r == 2'd3) begin
          rem_r <= acc_r + prod_r;
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      zvd_pkg::NS_ROOT: begin
        if (take) rem_r <= rem_r - trial;
        res_r <= res_new;
        bit_r <= bit_r >> 2;
        if (bit_r == 64'd1) norm_r <= res_new[31:0];
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign norm = norm_r;

endmodule
`default_nettype wire

>>> hw/rtl/zvd_div.sv
// Restoring divider, one quotient bit per cycle, for the window mean.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module zvd_div #(
  parameter int NW = 40,
  parameter int DW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic      [NW-1:0] quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   quo_r;
  logic [DW:0]     rem_r;
  logic [DW-1:0]   dvs_r;

  logic [DW:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_r[DW-1:0], quo_r[NW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNTW'(1));
      if (start) busy_r <= 1'b1;
      else if (cnt_r == CNTW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= CNTW'(NW);
    end else if (busy_r) begin
      // shift the next dividend bit in; quotient bits fill from the bottom
      rem_r <= fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_r <= {quo_r[NW-2:0], fits};
      cnt_r <= cnt_r - CNTW'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> hw/rtl/zero_velocity_detector.sv
// Top level of the zero-velocity detector: control sequencer, norm store,
// statistics datapath. Depends on zvd_pkg, zvd_ram, zvd_norm and zvd_div.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted sample is reduced to its vector norm (squaring on one
// multiplier, then a 32-step square root), written into the norm RAM and
// added to the running sum. A sample that closes the window is followed by
// the guard checks and, when the test runs, a mean division of one quotient
// bit per cycle (41 steps with the default WINDOW_MAX), a variance pass that
// reads the RAM at one entry a cycle, the test products on the shared
// multiplier and a compare state. One result per closing sample is held in
// an output register; the next sample is taken while it waits. Samples beyond
// WINDOW_MAX in one window are dropped. Configuration writes are always ready.
module zero_velocity_detector #(
  parameter int WINDOW_MAX = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire zvd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output zvd_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int AW  = $clog2(WINDOW_MAX);
  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int SW  = 32 + CW;
  localparam int SSW = 64 + CW;
  localparam int WW  = 74 + CW;

  zvd_pkg::main_state_t state_r, state_nxt;

  logic [8:0]  ws_r;
  logic [31:0] ref_mean_r;
  logic [31:0] ref_std_r;

  logic          end_r;
  logic [CW-1:0] count_r;
  logic [SW-1:0] sum_r;
  logic [7:0]    pass_r;
  logic [1:0]    status_r;

  logic [31:0]   mean_r;
  logic [31:0]   dm_r;
  logic [31:0]   k20_r;
  logic [31:0]   kt_r;
  logic [CW-1:0] rd_idx_r;
  logic          v1_r, v2_r, v3_r;
  logic [31:0]   d_r;
  logic [63:0]   sq_r;
  logic [SSW-1:0] ss_r;

  logic [2:0]    step_r;
  logic          phase_r;
  logic [63:0]   mul_r;
  logic [63:0]   std2_r;
  logic [63:0]   dm2_r;
  logic [WW-1:0] f_r;
  logic [WW-1:0] t_r;

  logic                out_valid_r;
  zvd_pkg::out_item_t  out_data_r;

  logic        norm_done;
  logic [31:0] norm;
  logic        div_done;
  logic [SW-1:0] quotient;
  logic [31:0] rdata;

  logic        accept;
  logic        full;
  logic        issue;
  logic        var_done;
  logic        out_free;
  logic [31:0] mul_a, mul_b;
  logic [WW-1:0] ss_w, ss25;
  logic        pass;
  logic        guard_fail;
  logic [1:0]  guard_status;
  logic        tiny;

  assign accept    = in_valid && in_ready;
  assign in_ready  = state_r == zvd_pkg::S_IDLE;
  assign cfg_ready = 1'b1;
  assign full      = count_r == CW'(WINDOW_MAX);
  assign out_free  = !out_valid_r || out_ready;

  zvd_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .vx    (in_data.accel_x),
    .vy    (in_data.accel_y),
    .vz    (in_data.accel_z),
    .done  (norm_done),
    .norm  (norm)
  );

  zvd_ram #(.WIDTH(32), .DEPTH(WINDOW_MAX)) u_store (
    .clk   (clk),
    .we    ((state_r == zvd_pkg::S_NORM) && norm_done && !full),
    .waddr (count_r[AW-1:0]),
    .wdata (norm),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rdata)
  );

  zvd_div #(.NW(SW), .DW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    ((state_r == zvd_pkg::S_EVAL) && !guard_fail && !tiny),
    .dividend (sum_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // guard checks on the closed window
  always_comb begin
    guard_fail   = 1'b1;
    guard_status = zvd_pkg::ST_TESTED;
    if (ws_r == 9'd0) begin
      guard_status = zvd_pkg::ST_DISABLED;
    end else if (32'(count_r) < 32'(ws_r)) begin
      guard_status = zvd_pkg::ST_TOO_FEW;
    end else if (ref_mean_r == 32'd0 || ref_std_r == 32'd0) begin
      guard_status = zvd_pkg::ST_INVALID;
    end else begin
      guard_fail = 1'b0;
    end
  end
  assign tiny = (32'(count_r) < 32'd2) || (ws_r < 9'd2);

  assign issue    = rd_idx_r < count_r;
  assign var_done = !issue && !v1_r && !v2_r && !v3_r;

  always_comb begin
    case (step_r)
      3'd0:    begin mul_a = ref_std_r;     mul_b = ref_std_r; end
      3'd1:    begin mul_a = std2_r[31:0];  mul_b = k20_r;     end
      3'd2:    begin mul_a = std2_r[63:32]; mul_b = k20_r;     end
      3'd3:    begin mul_a = dm_r;          mul_b = dm_r;      end
      3'd4:    begin mul_a = dm2_r[31:0];   mul_b = kt_r;      end
      3'd5:    begin mul_a = dm2_r[63:32];  mul_b = kt_r;      end
      default: begin mul_a = '0;            mul_b = '0;        end
    endcase
  end

  assign ss_w = WW'(ss_r);
  assign ss25 = (ss_w << 4) + (ss_w << 3) + ss_w;
  assign pass = (ss_w < f_r) && (t_r < ss25);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zvd_pkg::S_IDLE: if (accept) state_nxt = zvd_pkg::S_NORM;
      zvd_pkg::S_NORM: begin
        if (norm_done) state_nxt = end_r ? zvd_pkg::S_EVAL : zvd_pkg::S_IDLE;
      end
      zvd_pkg::S_EVAL: state_nxt = (guard_fail || tiny) ? zvd_pkg::S_EMIT : zvd_pkg::S_DIV;
      zvd_pkg::S_DIV:  if (div_done) state_nxt = zvd_pkg::S_VAR;
      zvd_pkg::S_VAR:  if (var_done) state_nxt = zvd_pkg::S_MUL;
      zvd_pkg::S_MUL:  if (phase_r && step_r == 3'd5) state_nxt = zvd_pkg::S_CMP;
      zvd_pkg::S_CMP:  state_nxt = zvd_pkg::S_EMIT;
      zvd_pkg::S_EMIT: if (out_free) state_nxt = zvd_pkg::S_IDLE;
      default:         state_nxt = zvd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zvd_pkg::S_IDLE;
      ws_r        <= '0;
      ref_mean_r  <= '0;
      ref_std_r   <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          zvd_pkg::REG_WINDOW_SIZE: ws_r       <= cfg_data[8:0];
          zvd_pkg::REG_REF_MEAN:    ref_mean_r <= cfg_data;
          zvd_pkg::REG_REF_STD:     ref_std_r  <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == zvd_pkg::S_NORM && norm_done && !full) begin
        sum_r   <= sum_r + SW'(norm);
        count_r <= count_r + CW'(1);
      end

      if (state_r == zvd_pkg::S_EVAL && (guard_fail || tiny)) pass_r <= '0;
      if (state_r == zvd_pkg::S_CMP) begin
        if (!pass) pass_r <= '0;
        else if (pass_r < zvd_pkg::COUNT_MAX) pass_r <= pass_r + 8'd1;
      end

      // read pipeline of the variance pass
      v1_r <= (state_r == zvd_pkg::S_VAR) && issue;
      v2_r <= v1_r;
      v3_r <= v2_r;

      if (state_r == zvd_pkg::S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        count_r     <= '0;
        sum_r       <= '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) end_r <= in_data.window_end;

    if (state_r == zvd_pkg::S_EVAL) begin
      status_r <= guard_fail ? guard_status : zvd_pkg::ST_TESTED;
      k20_r    <= 32'(count_r - CW'(1)) * zvd_pkg::F_FACTOR;
      kt_r     <= 32'(ws_r - 9'd1) * 32'(count_r - CW'(1));
    end

    if (state_r == zvd_pkg::S_DIV && div_done) begin
      mean_r   <= quotient[31:0];
      dm_r     <= (quotient[31:0] >= ref_mean_r) ? (quotient[31:0] - ref_mean_r)
                                                 : (ref_mean_r - quotient[31:0]);
      rd_idx_r <= '0;
      ss_r     <= '0;
      step_r   <= 3'd0;
      phase_r  <= 1'b0;
    end

    if (state_r == zvd_pkg::S_VAR && issue) rd_idx_r <= rd_idx_r + CW'(1);
    if (v1_r) d_r <= (rdata >= mean_r) ? (rdata - mean_r) : (mean_r - rdata);
    if (v2_r) sq_r <= d_r * d_r;
    if (v3_r) ss_r <= ss_r + SSW'(sq_r);

    if (state_r == zvd_pkg::S_MUL) begin
      phase_r <= !phase_r;
      if (!phase_r) begin
        mul_r <= mul_a * mul_b;
      end else begin
        step_r <= step_r + 3'd1;
        case (step_r)
          3'd0:    std2_r <= mul_r;
          3'd1:    f_r    <= WW'(mul_r);
          3'd2:    f_r    <= f_r + (WW'(mul_r) << 32);
          3'd3:    dm2_r  <= mul_r;
          3'd4:    t_r    <= WW'(mul_r);
          3'd5:    t_r    <= t_r + (WW'(mul_r) << 32);
          default: ;
        endcase
      end
    end

    if (state_r == zvd_pkg::S_EMIT && out_free) begin
      out_data_r.stationary  <= pass_r > zvd_pkg::STILL_LIMIT;
      out_data_r.test_status <= status_r;
      out_data_r.still_count <= pass_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> hw/rtl/zvd_checker.sv
// Port-level checks for the zero-velocity detector, bound to the top level.
// Depends on zvd_pkg and zero_velocity_detector.
`timescale 1ns / 1ps
`default_nettype none
module zvd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire zvd_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire zvd_pkg::out_item_t out_data
);

  // a stalled result transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_stationary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.stationary == (out_data.still_count > zvd_pkg::STILL_LIMIT))
    else $error("stationary flag disagrees with count");

  a_guard_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.test_status != zvd_pkg::ST_TESTED |-> out_data.still_count == 8'd0)
    else $error("guard failure kept a nonzero count");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_ready && !in_data.window_end |=> !out_valid)
    else $error("result without a closing sample");

endmodule

bind zero_velocity_detector zvd_checker u_zvd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

>>> dv/zero_velocity_detector_tb.sv
// Self-checking bench for zero_velocity_detector: window statistics and the
// stationary streak are recomputed here from the accepted samples. Needs zvd_pkg.
`timescale 1ns / 1ps
module zero_velocity_detector_tb;

  localparam int WMAX = 256;
  localparam int DRAIN_CYCLES = 700;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  zvd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  zvd_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  zero_velocity_detector #(.WINDOW_MAX(WMAX)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Mirror of the block's state and registers
  logic [31:0] norm_mem [WMAX];
  int unsigned fill;
  logic [39:0] norm_total;
  logic [7:0] streak;
  logic [8:0] win_len;
  logic [31:0] mean_ref;
  logic [31:0] std_ref;

  zvd_pkg::in_item_t sample_q[$];
  zvd_pkg::out_item_t verdict_q[$];
  int errors = 0;
  logic calm = 1'b0;
  int unsigned cycles = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs32(logic [31:0] a);
    return a[31] ? {32'd0, ~a + 32'd1} : {32'd0, a};
  endfunction

  function automatic bit window_still(int unsigned n);
    logic [127:0] mean, d, ss, lim, dm, lhs;
    if (n < 2 || win_len < 2) return 1'b0;
    mean = norm_total / n;
    ss = '0;
    for (int i = 0; i < n; i++) begin
      d = (norm_mem[i] >= mean) ? norm_mem[i] - mean : mean - norm_mem[i];
      ss = ss + d * d;
    end
    lim = 128'(std_ref) * std_ref * 20 * (n - 1);
    if (!(ss < lim)) return 1'b0;
    dm = (mean >= mean_ref) ? mean - mean_ref : mean_ref - mean;
    lhs = dm * dm * (win_len - 1) * (n - 1);
    return lhs < ss * 25;
  endfunction

  task automatic take_sample(zvd_pkg::in_item_t s);
    logic [63:0] mx, my, mz, nrm;
    zvd_pkg::out_item_t r;
    mx = abs32(s.accel_x);
    my = abs32(s.accel_y);
    mz = abs32(s.accel_z);
    nrm = int_sqrt(mx * mx + my * my + mz * mz);
    if (nrm > 64'hFFFF_FFFF) nrm = 64'hFFFF_FFFF;
    if (fill < WMAX) begin
      norm_mem[fill] = nrm[31:0];
      norm_total = norm_total + nrm[39:0];
      fill++;
    end
    if (!s.window_end) return;
    r.test_status = zvd_pkg::ST_TESTED;
    if (win_len == 0) begin
      r.test_status = zvd_pkg::ST_DISABLED;
      streak = '0;
    end else if (fill < win_len) begin
      r.test_status = zvd_pkg::ST_TOO_FEW;
      streak = '0;
    end else if (mean_ref == 0 || std_ref == 0) begin
      r.test_status = zvd_pkg::ST_INVALID;
      streak = '0;
    end else if (window_still(fill)) begin
      if (streak < zvd_pkg::COUNT_MAX) streak++;
    end else begin
      streak = '0;
    end
    fill = 0;
    norm_total = '0;
    r.stationary = streak > zvd_pkg::STILL_LIMIT;
    r.still_count = streak;
    verdict_q.push_back(r);
  endtask

  // Sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) take_sample(in_data);
      if (!in_valid || in_ready) begin
        if (sample_q.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
          in_valid <= 1'b1;
          in_data <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          errors++;
        end else begin
          zvd_pkg::out_item_t e;
          e = verdict_q.pop_front();
          if (out_data.stationary !== e.stationary) begin
            $error("stationary: expected %0d got %0d", e.stationary, out_data.stationary);
            errors++;
          end
          if (out_data.test_status !== e.test_status) begin
            $error("test_status: expected %0d got %0d", e.test_status,
                   out_data.test_status);
            errors++;
          end
          if (out_data.still_count !== e.still_count) begin
            $error("still_count: expected %0d got %0d", e.still_count,
                   out_data.still_count);
            errors++;
          end
        end
      end
      out_ready <= calm || $urandom_range(99) >= 15;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      zvd_pkg::REG_WINDOW_SIZE: win_len = val[8:0];
      zvd_pkg::REG_REF_MEAN:    mean_ref = val;
      zvd_pkg::REG_REF_STD:     std_ref = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every sample is in and every verdict is out, then let it settle
  task automatic drain();
    do @(posedge clk); while (sample_q.size() > 0 || in_valid || verdict_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void add(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
    zvd_pkg::in_item_t s;
    s.accel_x = x;
    s.accel_y = y;
    s.accel_z = z;
    s.window_end = last;
    sample_q.push_back(s);
  endfunction

  // Roughly 1 g on z with small jitter: the stationary case
  function automatic void add_still(bit last);
    add(32'($signed($urandom_range(512)) - 256), 32'($signed($urandom_range(512)) - 256),
        32'h0001_0000 + 32'($signed($urandom_range(1536)) - 768), last);
  endfunction

  function automatic void add_noise(bit last);
    add($urandom, $urandom, $urandom, last);
  endfunction

  initial begin
    int len;
    fill = 0;
    norm_total = '0;
    streak = '0;
    win_len = '0;
    mean_ref = '0;
    std_ref = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled after reset; extremes of every component
    add(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    add(32'h0, 32'h0, 32'h0, 1'b1);
    add(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    drain();

    // Invalid reference, then too few samples
    write_reg(zvd_pkg::REG_WINDOW_SIZE, 32'd4);
    write_reg(zvd_pkg::REG_REF_STD, 32'h0000_1000);
    for (int i = 0; i < 4; i++) add_still(i == 3);
    add_still(1'b0);
    add_still(1'b1);
    drain();

    // Tiny window; unused index must be ignored
    write_reg(zvd_pkg::REG_WINDOW_SIZE, 32'd1);
    write_reg(zvd_pkg::REG_REF_MEAN, 32'h0001_0000);
    write_reg(zvd_pkg::REG_REF_STD, 32'hFFFF_FFFF);
    write_reg(2'd3, 32'hFFFF_FFFF);
    add_still(1'b1);
    drain();

    // Zero variance, then a window longer than required
    write_reg(zvd_pkg::REG_WINDOW_SIZE, 32'd3);
    for (int i = 0; i < 3; i++) add(32'h0, 32'h0, 32'h0001_0000, i == 2);
    for (int i = 0; i < 5; i++) add_still(i == 4);
    drain();

    // Window larger than the store can hold
    write_reg(zvd_pkg::REG_WINDOW_SIZE, 32'd511);
    for (int i = 0; i < 5; i++) add_still(i == 4);
    drain();

    // Stationary run without idling: drive the streak past the threshold
    write_reg(zvd_pkg::REG_WINDOW_SIZE, 32'd2);
    write_reg(zvd_pkg::REG_REF_MEAN, 32'h0001_0000);
    write_reg(zvd_pkg::REG_REF_STD, 32'h0000_1000);
    calm = 1'b1;
    for (int w = 0; w < 20; w++) begin
      add(32'h0, 32'h0, 32'h0001_0100 + $urandom_range(63), 1'b0);
      add(32'h0, 32'h0, 32'h0000_FF00 - $urandom_range(63), 1'b1);
    end
    drain();
    calm = 1'b0;

    // Mixed windows: mostly stationary, some noise, some cut short
    write_reg(zvd_pkg::REG_WINDOW_SIZE, 32'd8);
    for (int w = 0; w < 10; w++) begin
      len = $urandom_range(99) < 15 ? $urandom_range(1, 7) : $urandom_range(8, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 75) add_still(i == len - 1);
        else add_noise(i == len - 1);
      end
    end
    drain();

    // Full store with the largest reference values; overflowing window drops samples
    write_reg(zvd_pkg::REG_WINDOW_SIZE, 32'd256);
    write_reg(zvd_pkg::REG_REF_MEAN, 32'hFFFF_FFFF);
    write_reg(zvd_pkg::REG_REF_STD, 32'hFFFF_FFFF);
    for (int i = 0; i < 260; i++) add_noise(i == 259);
    drain();

    if (errors == 0 && verdict_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (verdict_q.size() > 0) $error("%0d expected results never came", verdict_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
